// ----- hw/rtl/lcr_pkg.sv -----
// Shared types, constants and codes for the load cell reader.
`default_nettype none

package lcr_pkg;

   localparam int DATA_BITS = 24;

   localparam int RAW_W   = 24;
   localparam int FORCE_W = 19;
   localparam int SCALE_W = 24;
   localparam int ANGLE_W = 8;
   localparam int TMO_W   = 16;
   localparam int CSR_W   = 24;
   localparam int PROD_W  = RAW_W + SCALE_W;
   localparam int MG_W    = PROD_W - 16;
   localparam int G_W     = 10;
   localparam int FQ_W    = MG_W + G_W;
   localparam int OFF_W   = 11;

   typedef logic [RAW_W-1:0]   raw_type;
   typedef logic [FORCE_W-1:0] force_type;
   typedef logic [SCALE_W-1:0] scale_type;
   typedef logic [ANGLE_W-1:0] angle_type;
   typedef logic [TMO_W-1:0]   tmo_type;
   typedef logic [CSR_W-1:0]   csr_data_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [MG_W-1:0]    mg_type;
   typedef logic [FQ_W-1:0]    fq_type;
   typedef logic [OFF_W-1:0]   off_type;
   typedef logic [1:0]         csr_idx_type;

   localparam csr_idx_type CSR_TARE    = 2'd0;
   localparam csr_idx_type CSR_SCALE   = 2'd1;
   localparam csr_idx_type CSR_ANGLE   = 2'd2;
   localparam csr_idx_type CSR_TIMEOUT = 2'd3;

   localparam raw_type   TARE_RST    = 24'd7933904;
   localparam scale_type SCALE_RST   = 24'd143911;
   localparam angle_type ANGLE_RST   = 8'd90;
   localparam tmo_type   TIMEOUT_RST = 16'd200;

   localparam logic [G_W-1:0] G_Q16     = 10'd643;
   localparam angle_type      ANGLE_A   = 8'd120;
   localparam angle_type      ANGLE_B   = 8'd150;
   localparam off_type        OFFSET_A  = 11'd1000;
   localparam off_type        OFFSET_B  = 11'd1700;
   localparam force_type      FORCE_MAX = 19'd524287;

   typedef struct packed {
      logic start_req;
      logic dt_level;
      logic ms_tick;
   } req_type;

   typedef struct packed {
      logic      sck;
      logic      done_res;
      logic      timed_out;
      raw_type   raw_count;
      force_type force_mn;
   } rsp_type;

   typedef enum logic [5:0] {
      PH_IDLE       = 6'b000001,
      PH_WAIT       = 6'b000010,
      PH_BIT_HIGH   = 6'b000100,
      PH_BIT_LOW    = 6'b001000,
      PH_EXTRA_HIGH = 6'b010000,
      PH_EXTRA_LOW  = 6'b100000
   } phase_type;

   typedef enum logic [3:0] {
      SEQ_RUN   = 4'b0001,
      SEQ_PROD  = 4'b0010,
      SEQ_SCALE = 4'b0100,
      SEQ_TRIM  = 4'b1000
   } seq_type;

   typedef struct packed {
      logic take;
      logic sck;
      logic shift_clr;
      logic shift_left;
      logic shift_in;
      logic wait_clr;
      logic wait_inc;
      logic finish_data;
      logic finish_tout;
      logic load_prod;
      logic load_scale;
      logic load_force;
   } cmd_type;

   typedef struct packed {
      logic wait_full;
   } stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lcr_ctrl.sv -----
// Controller: serial link phase machine, bit counter, scaling sequencer and handshake.
`default_nettype none

module lcr_ctrl #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS
) (
   input  wire                logic     clock,
   input  wire                logic     reset,
   input  wire                logic     req_valid,
   output logic                         req_ready,
   input  wire                lcr_pkg::req_type req_data,
   output logic                         rsp_valid,
   input  wire                logic     rsp_ready,
   input  wire                lcr_pkg::stat_type stat,
   output lcr_pkg::cmd_type             cmd
);

   localparam int CntW = $clog2(DATA_BITS);

   lcr_pkg::phase_type phase_ff, phase_in;
   lcr_pkg::seq_type   seq_ff, seq_in;
   logic [CntW-1:0]    bit_cnt_ff, bit_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               take;
   logic               finish;
   logic               bit_last;

   assign req_ready = (seq_ff == lcr_pkg::SEQ_RUN) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;
   assign bit_last  = (bit_cnt_ff == CntW'(DATA_BITS - 1));

   always_comb begin
      cmd            = '0;
      cmd.take       = take;
      cmd.load_prod  = (seq_ff == lcr_pkg::SEQ_PROD);
      cmd.load_scale = (seq_ff == lcr_pkg::SEQ_SCALE);
      cmd.load_force = (seq_ff == lcr_pkg::SEQ_TRIM);
      phase_in       = phase_ff;
      bit_cnt_in     = bit_cnt_ff;
      if (take) begin
         case (phase_ff)
            lcr_pkg::PH_IDLE: begin
               if (req_data.start_req) begin
                  phase_in      = lcr_pkg::PH_WAIT;
                  cmd.wait_clr  = 1'b1;
                  cmd.shift_clr = 1'b1;
                  bit_cnt_in    = '0;
               end
            end
            lcr_pkg::PH_WAIT: begin
               if (!req_data.dt_level) begin
                  phase_in      = lcr_pkg::PH_BIT_HIGH;
                  cmd.shift_clr = 1'b1;
                  bit_cnt_in    = '0;
               end else if (req_data.ms_tick) begin
                  if (stat.wait_full) begin
                     phase_in        = lcr_pkg::PH_IDLE;
                     cmd.finish_tout = 1'b1;
                     cmd.wait_clr    = 1'b1;
                     bit_cnt_in      = '0;
                  end else begin
                     cmd.wait_inc = 1'b1;
                  end
               end
            end
            lcr_pkg::PH_BIT_HIGH: begin
               cmd.sck        = 1'b1;
               cmd.shift_left = 1'b1;
               phase_in       = lcr_pkg::PH_BIT_LOW;
            end
            lcr_pkg::PH_BIT_LOW: begin
               cmd.shift_in = 1'b1;
               bit_cnt_in   = bit_cnt_ff + 1'b1;
               phase_in     = bit_last ? lcr_pkg::PH_EXTRA_HIGH : lcr_pkg::PH_BIT_HIGH;
            end
            lcr_pkg::PH_EXTRA_HIGH: begin
               cmd.sck  = 1'b1;
               phase_in = lcr_pkg::PH_EXTRA_LOW;
            end
            lcr_pkg::PH_EXTRA_LOW: begin
               cmd.finish_data = 1'b1;
               cmd.wait_clr    = 1'b1;
               bit_cnt_in      = '0;
               phase_in        = lcr_pkg::PH_IDLE;
            end
            default: begin
               phase_in = lcr_pkg::PH_IDLE;
            end
         endcase
      end
   end

   assign finish = cmd.finish_data || cmd.finish_tout;

   // hold the result beat until taken; a completing tick runs the scaling steps first
   always_comb begin
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff;
      case (seq_ff)
         lcr_pkg::SEQ_RUN: begin
            if (take) begin
               if (finish) begin
                  seq_in       = lcr_pkg::SEQ_PROD;
                  rsp_valid_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         lcr_pkg::SEQ_PROD: begin
            seq_in = lcr_pkg::SEQ_SCALE;
         end
         lcr_pkg::SEQ_SCALE: begin
            seq_in = lcr_pkg::SEQ_TRIM;
         end
         lcr_pkg::SEQ_TRIM: begin
            seq_in       = lcr_pkg::SEQ_RUN;
            rsp_valid_in = 1'b1;
         end
         default: begin
            seq_in       = lcr_pkg::SEQ_RUN;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lcr_pkg::PH_IDLE;
         seq_ff       <= lcr_pkg::SEQ_RUN;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_finish_starts_scaling : assert property (@(posedge clock) disable iff (reset)
      (take && finish) |=> (seq_ff == lcr_pkg::SEQ_PROD) && !rsp_valid_ff)
      else $error("completing beat did not start the scaling steps");

   a_trim_presents : assert property (@(posedge clock) disable iff (reset)
      (seq_ff == lcr_pkg::SEQ_TRIM) |=> rsp_valid_ff && (seq_ff == lcr_pkg::SEQ_RUN))
      else $error("scaled result was not presented");

   a_plain_beat_presents : assert property (@(posedge clock) disable iff (reset)
      (take && !finish) |=> rsp_valid_ff)
      else $error("plain beat produced no result");

   a_last_bit : assert property (@(posedge clock) disable iff (reset)
      (take && (phase_ff == lcr_pkg::PH_BIT_LOW) && bit_last)
         |=> (phase_ff == lcr_pkg::PH_EXTRA_HIGH))
      else $error("last data bit did not lead to the extra pulse");

   a_busy_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (seq_ff != lcr_pkg::SEQ_RUN) |-> !req_ready)
      else $error("input accepted during scaling");

endmodule

`default_nettype wire

// ----- hw/rtl/lcr_dp.sv -----
// Datapath: settings, shift register, wait counter, force scaling and result register.
`default_nettype none

module lcr_dp #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS
) (
   input  wire                logic     clock,
   input  wire                logic     reset,
   input  wire                logic     csr_we,
   input  wire                lcr_pkg::csr_idx_type  csr_index,
   input  wire                lcr_pkg::csr_data_type csr_wdata,
   input  wire                lcr_pkg::req_type      req_data,
   input  wire                lcr_pkg::cmd_type      cmd,
   output lcr_pkg::stat_type                         stat,
   output lcr_pkg::rsp_type                          rsp_data
);

   localparam logic [DATA_BITS-1:0] TopBit = {1'b1, {(DATA_BITS-1){1'b0}}};

   lcr_pkg::raw_type    tare_ff;
   lcr_pkg::scale_type  scale_ff;
   lcr_pkg::angle_type  angle_ff;
   lcr_pkg::tmo_type    tmo_ff;

   logic [DATA_BITS-1:0] shift_ff, shift_in;
   lcr_pkg::tmo_type     wait_ff, wait_in;
   logic                 neg_ff, neg_in;
   lcr_pkg::raw_type     dmag_ff, dmag_in;
   lcr_pkg::prod_type    prod_ff, prod_in;
   lcr_pkg::fq_type      f_ff, f_in;
   lcr_pkg::rsp_type     out_ff, out_in;

   logic [DATA_BITS-1:0] raw_full;
   lcr_pkg::raw_type     raw_sel;
   lcr_pkg::mg_type      mg;
   lcr_pkg::off_type     off;
   lcr_pkg::fq_type      off_q16;
   lcr_pkg::fq_type      f_diff;
   logic [lcr_pkg::FQ_W-17:0] f_int;
   lcr_pkg::force_type   force_val;

   assign stat.wait_full = (wait_ff >= tmo_ff);
   assign rsp_data       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff  <= lcr_pkg::TARE_RST;
         scale_ff <= lcr_pkg::SCALE_RST;
         angle_ff <= lcr_pkg::ANGLE_RST;
         tmo_ff   <= lcr_pkg::TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            lcr_pkg::CSR_TARE:    tare_ff  <= lcr_pkg::raw_type'(csr_wdata);
            lcr_pkg::CSR_SCALE:   scale_ff <= lcr_pkg::scale_type'(csr_wdata);
            lcr_pkg::CSR_ANGLE:   angle_ff <= lcr_pkg::angle_type'(csr_wdata);
            lcr_pkg::CSR_TIMEOUT: tmo_ff   <= lcr_pkg::tmo_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      shift_in = shift_ff;
      if (cmd.shift_clr) begin
         shift_in = '0;
      end else if (cmd.shift_left) begin
         shift_in = {shift_ff[DATA_BITS-2:0], 1'b0};
      end else if (cmd.shift_in) begin
         shift_in = {shift_ff[DATA_BITS-1:1], shift_ff[0] | req_data.dt_level};
      end
      wait_in = wait_ff;
      if (cmd.wait_clr) begin
         wait_in = '0;
      end else if (cmd.wait_inc) begin
         wait_in = wait_ff + 1'b1;
      end
   end

   // flip the sign bit, keep the low field bits
   assign raw_full = shift_ff ^ TopBit;
   assign raw_sel  = cmd.finish_data ? lcr_pkg::raw_type'(raw_full) : '0;

   always_comb begin
      neg_in  = (raw_sel < tare_ff);
      dmag_in = neg_in ? (tare_ff - raw_sel) : (raw_sel - tare_ff);
   end

   assign prod_in = lcr_pkg::prod_type'(dmag_ff) * lcr_pkg::prod_type'(scale_ff);
   assign mg      = prod_ff[lcr_pkg::PROD_W-1:16];
   assign f_in    = lcr_pkg::fq_type'(mg) * lcr_pkg::fq_type'(lcr_pkg::G_Q16);

   always_comb begin
      if (angle_ff == lcr_pkg::ANGLE_A) begin
         off = lcr_pkg::OFFSET_A;
      end else if (angle_ff == lcr_pkg::ANGLE_B) begin
         off = lcr_pkg::OFFSET_B;
      end else begin
         off = '0;
      end
      off_q16 = lcr_pkg::fq_type'({off, 16'b0});
      f_diff  = f_ff - off_q16;
      f_int   = f_diff[lcr_pkg::FQ_W-1:16];
      if (neg_ff || (f_ff <= off_q16)) begin
         force_val = '0;
      end else if (f_int > {{(lcr_pkg::FQ_W-16-lcr_pkg::FORCE_W){1'b0}}, lcr_pkg::FORCE_MAX}) begin
         force_val = lcr_pkg::FORCE_MAX;
      end else begin
         force_val = f_int[lcr_pkg::FORCE_W-1:0];
      end
   end

   always_comb begin
      out_in = out_ff;
      if (cmd.take) begin
         out_in.sck       = cmd.sck;
         out_in.done_res  = cmd.finish_data || cmd.finish_tout;
         out_in.timed_out = cmd.finish_tout;
         out_in.raw_count = raw_sel;
         out_in.force_mn  = '0;
      end else if (cmd.load_force) begin
         out_in.force_mn = force_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         wait_ff  <= '0;
      end else begin
         shift_ff <= shift_in;
         wait_ff  <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (cmd.take && (cmd.finish_data || cmd.finish_tout)) begin
         neg_ff  <= neg_in;
         dmag_ff <= dmag_in;
      end
      if (cmd.load_prod) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_scale) begin
         f_ff <= f_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/load_cell_reader_force_scaler.sv -----
// Load cell reader with force scaling: top level.
//
// Each input beat on req_ (valid/ready) is one tick of the serial link: start
// request, sampled data pin level and millisecond strobe. Each beat yields
// exactly one result beat on rsp_: the clock pin level for that tick, and on
// the tick a reading completes, done_res, timed_out, raw_count and force_mn.
// Settings are written by the user through csr_we/csr_index/csr_wdata only
// while idle, which the block does not enforce: 0 tare count, 1 scale (Q16
// mg per count), 2 arm angle, 3 timeout in ms.
//
// An ordinary tick presents its result in the cycle after acceptance. A
// completing tick runs its scaling steps in order: the 24x24 scale multiply,
// the multiply by 643 and the offset/clamp step each have a register stage.
// Beats are taken one per cycle while the receiver keeps up; the input is
// held off during those steps. A result waiting on a stalled receiver holds;
// a new beat is accepted in the same cycle the waiting one is taken.
// Reset (synchronous) returns to idle and loads the default settings; the
// result register, serial clock level included, is not reset.
`default_nettype none

module load_cell_reader_force_scaler #(
   parameter int DATA_BITS = lcr_pkg::DATA_BITS
) (
   input  wire                logic                  clock,
   input  wire                logic                  reset,
   input  wire                logic                  req_valid,
   output logic                                      req_ready,
   input  wire                lcr_pkg::req_type      req_data,
   output logic                                      rsp_valid,
   input  wire                logic                  rsp_ready,
   output lcr_pkg::rsp_type                          rsp_data,
   input  wire                logic                  csr_we,
   input  wire                lcr_pkg::csr_idx_type  csr_index,
   input  wire                lcr_pkg::csr_data_type csr_wdata
);

   lcr_pkg::cmd_type  cmd;
   lcr_pkg::stat_type stat;

   lcr_ctrl #(
      .DATA_BITS (DATA_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lcr_dp #(
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
